FILE: rtl/core/stfla_pkg.sv
// Shared constants, codes and types for the slot table free list allocator.
package stfla_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int LINK_W        = IDX_W + 1;
  localparam int SLOT_W        = 6;
  localparam int ADDR_W        = 64;

  localparam logic [LINK_W-1:0] HEAD_EMPTY = LINK_W'(TABLE_ENTRIES);
  localparam logic [LINK_W-1:0] FRESH_FULL = LINK_W'(TABLE_ENTRIES);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic STAT_DONE = 1'b0;
  localparam logic STAT_FULL = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } ctrl_state_t;

  // Requests from the controller to the slot store.
  typedef struct packed {
    logic              link_we;
    logic [IDX_W-1:0]  link_waddr;
    logic [LINK_W-1:0] link_wdata;
    logic              link_re;
    logic [IDX_W-1:0]  link_raddr;
    logic              addr_we;
    logic [IDX_W-1:0]  addr_waddr;
    logic [ADDR_W-1:0] addr_wdata;
  } mem_req_t;

  // Result handed to the output register.
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] given_index;
    logic              status;
  } result_t;

endpackage

FILE: rtl/core/stfla_store.sv
// Slot store: free-list link memory and object address memory.
module stfla_store import stfla_pkg::*; (
  input  logic              clk,
  input  mem_req_t          req,
  output logic [LINK_W-1:0] link_rdata
);

  logic [LINK_W-1:0] link_mem [TABLE_ENTRIES];
  logic [ADDR_W-1:0] addr_mem [TABLE_ENTRIES];
  logic [LINK_W-1:0] link_rdata_r;

  always_ff @(posedge clk) begin
    if (req.link_we) begin
      link_mem[req.link_waddr] <= req.link_wdata;
    end
    if (req.link_re) begin
      link_rdata_r <= link_mem[req.link_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.addr_we) begin
      addr_mem[req.addr_waddr] <= req.addr_wdata;
    end
  end

  assign link_rdata = link_rdata_r;

endmodule

FILE: rtl/core/stfla_ctrl.sv
// Allocator control: item capture, head/fresh registers and commit sequencing.
module stfla_ctrl import stfla_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              command,
  input  logic [ADDR_W-1:0] object_address,
  input  logic [SLOT_W-1:0] slot_index,
  input  logic              out_free,
  input  logic [LINK_W-1:0] link_rdata,
  output mem_req_t          req,
  output result_t           res
);

  ctrl_state_t       state_r, state_nxt;
  logic              cmd_r;
  logic [ADDR_W-1:0] addr_r;
  logic [SLOT_W-1:0] slot_r;
  logic [LINK_W-1:0] head_r, head_nxt;
  logic [LINK_W-1:0] fresh_r, fresh_nxt;

  logic              accept;
  logic              commit;
  logic              from_list;
  logic              from_fresh;
  logic              free_ok;
  logic [IDX_W-1:0]  alloc_idx;
  logic [LINK_W-1:0] popped_head;

  assign accept = in_valid && in_ready;
  assign commit = (state_r == ST_EXEC) && out_free;

  assign from_list   = (head_r != HEAD_EMPTY);
  assign from_fresh  = !from_list && (fresh_r != FRESH_FULL);
  assign alloc_idx   = from_list ? head_r[IDX_W-1:0] : fresh_r[IDX_W-1:0];
  // a link never exceeds the empty marker; clamp anyway
  assign popped_head = (link_rdata > HEAD_EMPTY) ? HEAD_EMPTY : link_rdata;
  assign free_ok     = (32'(slot_r) < 32'(TABLE_ENTRIES)) && (32'(slot_r) < 32'(fresh_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_EXEC;
      ST_EXEC: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready        = (state_r == ST_IDLE);
    req             = '0;
    req.link_re     = accept;
    req.link_raddr  = head_r[IDX_W-1:0];
    req.addr_waddr  = alloc_idx;
    req.addr_wdata  = addr_r;
    req.link_waddr  = IDX_W'(slot_r);
    req.link_wdata  = head_r;
    res             = '0;
    head_nxt        = head_r;
    fresh_nxt       = fresh_r;
    if (commit) begin
      res.valid = 1'b1;
      if (cmd_r == CMD_ALLOC) begin
        if (from_list || from_fresh) begin
          req.addr_we     = 1'b1;
          res.given_index = SLOT_W'(alloc_idx);
          res.status      = STAT_DONE;
          if (from_list) begin
            head_nxt = popped_head;
          end else begin
            fresh_nxt = fresh_r + LINK_W'(1);
          end
        end else begin
          res.status = STAT_FULL;
        end
      end else begin
        res.status = STAT_DONE;
        if (free_ok) begin
          req.link_we = 1'b1;
          head_nxt    = LINK_W'(IDX_W'(slot_r));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r  <= HEAD_EMPTY;
      fresh_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      fresh_r <= fresh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= command;
      addr_r <= object_address;
      slot_r <= slot_index;
    end
  end

endmodule

FILE: rtl/core/slot_table_free_list_allocator_core.sv
// Top level of the slot table free list allocator: controller, slot store, output register.
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+------------------------------------------
//  in_     | input     | in_valid / in_ready  | command, object_address, slot_index
//  out_    | output    | out_valid / out_ready| given_index, status
//
// Each word is handled as an accept (link memory read of the free-list head
// issued at the same edge), then a commit once the output register can take the
// result; the link memory read is registered.
// Reset (rst_n, synchronous) empties the free list and the fresh counter; the
// memories need no clearing. A stalled output holds the commit back, but the
// next word is still accepted while a finished result waits in out_.
module slot_table_free_list_allocator_core import stfla_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_command,
  input  logic [ADDR_W-1:0] in_object_address,
  input  logic [SLOT_W-1:0] in_slot_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SLOT_W-1:0] out_given_index,
  output logic              out_status
);

  mem_req_t          req;
  result_t           res;
  logic [LINK_W-1:0] link_rdata;
  logic              out_free;

  logic              out_valid_r;
  logic [SLOT_W-1:0] out_index_r;
  logic              out_status_r;

  // output register can take a new result when empty or draining this cycle
  assign out_free = !out_valid_r || out_ready;

  stfla_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (in_command),
    .object_address (in_object_address),
    .slot_index     (in_slot_index),
    .out_free       (out_free),
    .link_rdata     (link_rdata),
    .req            (req),
    .res            (res)
  );

  stfla_store u_store (
    .clk        (clk),
    .req        (req),
    .link_rdata (link_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_index_r  <= res.given_index;
      out_status_r <= res.status;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_given_index = out_index_r;
  assign out_status      = out_status_r;

endmodule

FILE: rtl/core/stfla_checker.sv
// Port-level checker for the allocator core, bound to the top level.
module stfla_checker import stfla_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [SLOT_W-1:0] out_given_index,
  input logic              out_status
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_given_index) && $stable(out_status))
    else $error("result changed while stalled");

  // a refused allocation carries index zero
  a_full_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_FULL) |-> out_given_index == '0)
    else $error("table full result with nonzero index");

  // one word at a time: no accept in the cycle after an accept
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a word is in flight");

  // reset empties the output
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind slot_table_free_list_allocator_core stfla_checker u_stfla_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_given_index (out_given_index),
  .out_status      (out_status)
);

FILE: tb/slot_table_free_list_allocator_core_test.sv
// Testbench for the slot table free list allocator: scoreboard against a LIFO free list predictor.
module slot_table_free_list_allocator_core_test;
  import stfla_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no word moving on either side before the run is declared hung.
  // The worst stall from the receiver plus a sender gap stays far below this.
  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 10;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [SLOT_W-1:0] given_index;
    logic              status;
  } reply_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic              in_command;
  logic [ADDR_W-1:0] in_object_address;
  logic [SLOT_W-1:0] in_slot_index;
  logic              out_valid;
  logic              out_ready;
  logic [SLOT_W-1:0] out_given_index;
  logic              out_status;

  slot_table_free_list_allocator_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_object_address(in_object_address),
    .in_slot_index    (in_slot_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_given_index  (out_given_index),
    .out_status       (out_status)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Predicted allocator state: link per slot, head of the freed list and the
  // count of slots ever taken from the never-used range.
  logic [LINK_W-1:0] chain_next [TABLE_ENTRIES];
  logic [LINK_W-1:0] chain_top;
  logic [LINK_W-1:0] unused_base;

  reply_t replies_due[$];   // predicted results, oldest first
  int     in_use_slots[$];  // slots handed out and not yet freed

  int mismatches;
  int stray_replies;
  int grants;
  int refusals;
  int frees_taken;
  int frees_ignored;
  int quiet_cycles;
  int burst_left;
  logic last_refused;

  // One word through the allocator; updates the predicted state.
  function automatic reply_t predict_reply(input logic cmd, input logic [SLOT_W-1:0] slot);
    reply_t r;
    r.given_index = '0;
    r.status      = STAT_DONE;
    if (cmd == CMD_ALLOC) begin
      if (chain_top != HEAD_EMPTY) begin
        // Most recently freed slot goes first.
        r.given_index = chain_top[SLOT_W-1:0];
        chain_top     = chain_next[chain_top[IDX_W-1:0]];
        grants++;
      end else if (unused_base != FRESH_FULL) begin
        r.given_index = unused_base[SLOT_W-1:0];
        unused_base   = unused_base + 1'b1;
        grants++;
      end else begin
        r.status = STAT_FULL;
        refusals++;
      end
    end else begin
      // Only slots already handed out may go back on the list; no double-free check.
      if (LINK_W'(slot) < unused_base) begin
        chain_next[slot[IDX_W-1:0]] = chain_top;
        chain_top                   = LINK_W'(slot);
        frees_taken++;
      end else begin
        frees_ignored++;
      end
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] rand_address();
    return {$urandom, $urandom};
  endfunction

  // Sender: bursts of words with random gaps; valid held until accepted.
  task automatic send_word(input logic cmd, input logic [ADDR_W-1:0] addr,
                           input logic [SLOT_W-1:0] slot);
    int     gap;
    reply_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(16, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
      repeat (gap) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid          = 1'b1;
    in_command        = cmd;
    in_object_address = addr;
    in_slot_index     = slot;
    do @(posedge clk); while (!in_ready);
    r = predict_reply(cmd, slot);
    replies_due.push_back(r);
    last_refused = r.status;
    if (cmd == CMD_ALLOC && r.status == STAT_DONE) in_use_slots.push_back(int'(r.given_index));
  endtask

  task automatic alloc_word();
    send_word(CMD_ALLOC, rand_address(), SLOT_W'($urandom));
  endtask

  // Free a slot; drops it from the in-use list if it was there.
  task automatic free_slot(input int slot);
    int hits[$];
    hits = in_use_slots.find_first_index(x) with (x == slot);
    if (hits.size() != 0) in_use_slots.delete(hits[0]);
    send_word(CMD_FREE, rand_address(), SLOT_W'(slot));
  endtask

  task automatic free_held();
    int k;
    int s;
    if (in_use_slots.size() == 0) begin
      alloc_word();
    end else begin
      k = $urandom_range(in_use_slots.size() - 1, 0);
      s = in_use_slots[k];
      free_slot(s);
    end
  endtask

  // Noise: free of a slot never handed out, ignored by the block.
  task automatic free_stray();
    if (unused_base != FRESH_FULL)
      send_word(CMD_FREE, rand_address(),
                SLOT_W'($urandom_range(TABLE_ENTRIES - 1, int'(unused_base))));
    else
      alloc_word();
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    in_valid = 1'b0;
    burst_left = 0;
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  // Extremes of the fields, LIFO reuse order and ignored frees.
  task automatic test_directed();
    send_word(CMD_ALLOC, '0, '0);
    send_word(CMD_ALLOC, '1, '1);
    send_word(CMD_FREE, '1, '1);             // beyond the used range
    send_word(CMD_FREE, '0, SLOT_W'(2));     // equal to the fresh count
    free_slot(0);
    free_slot(1);
    alloc_word();                             // slot 1 back first
    alloc_word();                             // then slot 0
    alloc_word();                             // then a fresh slot
    free_slot(2);
    send_word(CMD_ALLOC, '1, '0);
    free_slot(0);
    send_word(CMD_ALLOC, 64'h8000_0000_0000_0001, 6'h2A);
  endtask

  // Use every slot, run into the full table, then hand everything back and allocate again.
  task automatic test_fill_to_full();
    int extra;
    last_refused = STAT_DONE;
    while (last_refused != STAT_FULL) alloc_word();
    alloc_word();
    alloc_word();
    // Pause until the table-full replies have all come back.
    wait_for_drain();
    while (in_use_slots.size() != 0) free_held();
    extra = $urandom_range(12, 6);
    repeat (extra) alloc_word();
  endtask

  // Mixed allocate/free traffic with a drifting bias so the list grows and shrinks.
  task automatic test_random_mix();
    int bias;
    int pick;
    for (int phase = 0; phase < 3; phase++) begin
      bias = (phase == 0) ? 75 : (phase == 1) ? 25 : 55;
      repeat (80) begin
        pick = $urandom_range(99, 0);
        if (pick < 10) free_stray();
        else if (pick < 10 + bias * 90 / 100) alloc_word();
        else free_held();
      end
    end
    wait_for_drain();
  endtask

  // Freeing one slot twice loops the list on itself; runs last for that reason.
  task automatic test_double_free();
    int s;
    if (in_use_slots.size() == 0) alloc_word();
    s = in_use_slots[0];
    free_slot(s);
    send_word(CMD_FREE, rand_address(), SLOT_W'(s));
    repeat (3) alloc_word();
    free_stray();
    alloc_word();
  endtask

  // Receiver: ready pattern switches between modes, each held for a random span.
  initial begin
    int mode;
    int span;
    int tick;
    out_ready = 1'b0;
    tick = 0;
    forever begin
      mode = $urandom_range(3, 0);
      span = $urandom_range(40, 8);
      repeat (span) begin
        @(negedge clk);
        tick++;
        case (mode)
          0: begin
            out_ready = 1'b1;
          end
          1: begin
            out_ready = 1'($urandom_range(1, 0));
          end
          2: begin
            out_ready = (tick % 4 == 0);
          end
          default: begin
            out_ready = ($urandom_range(9, 0) == 0);
          end
        endcase
      end
    end
  end

  // Result checker against the oldest prediction.
  always @(posedge clk) begin
    reply_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (replies_due.size() == 0) begin
        stray_replies++;
        if (mismatches + stray_replies <= MAX_REPORTS)
          $display("unexpected result: given_index %0d status %0d",
                   out_given_index, out_status);
      end else begin
        exp_r = replies_due.pop_front();
        if (out_given_index !== exp_r.given_index || out_status !== exp_r.status) begin
          mismatches++;
          if (mismatches + stray_replies <= MAX_REPORTS)
            $display("mismatch: given_index exp %0d got %0d, status exp %0d got %0d",
                     exp_r.given_index, out_given_index, exp_r.status, out_status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("hang: no word moved for %0d cycles", QUIET_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_command        = CMD_ALLOC;
    in_object_address = '0;
    in_slot_index     = '0;
    chain_top         = HEAD_EMPTY;
    unused_base       = '0;
    mismatches        = 0;
    stray_replies     = 0;
    grants            = 0;
    refusals          = 0;
    frees_taken       = 0;
    frees_ignored     = 0;
    quiet_cycles      = 0;
    burst_left        = 0;
    last_refused      = STAT_DONE;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_fill_to_full();
    test_random_mix();
    test_double_free();

    @(negedge clk);
    in_valid = 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d grants, %0d table-full refusals, %0d frees taken, %0d frees ignored",
             grants, refusals, frees_taken, frees_ignored);
    $display("%0d mismatches, %0d unexpected results, %0d results missing",
             mismatches, stray_replies, replies_due.size());
    if (mismatches == 0 && stray_replies == 0 && replies_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
